[design/bgp_as_path_parser_assert.svh]
// Assertion macros used by the AS_PATH parser top level.
`ifndef BGP_AS_PATH_PARSER_ASSERT_SVH
`define BGP_AS_PATH_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BGPAP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bgp_as_path_parser: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BGPAP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bgp_as_path_parser: next-cycle check failed");

`endif

[design/bgpap_pkg.sv]
// Types, codes and the hash mix function of the AS_PATH parser.
package bgpap_pkg;

    typedef enum logic [1:0] {
        PH_TYPE  = 2'd0,
        PH_COUNT = 2'd1,
        PH_ASN   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        SEG_SEQ  = 2'd0,
        SEG_SET  = 2'd1,
        SEG_CSET = 2'd2,
        SEG_CSEQ = 2'd3
    } t_seg_kind;

    typedef enum logic [1:0] {
        RES_ASN      = 2'd0,
        RES_DONE     = 2'd1,
        RES_BAD_TYPE = 2'd2,
        RES_TRUNC    = 2'd3
    } t_res_kind;

    // Segment type bytes on the wire
    localparam logic [7:0] WIRE_SET  = 8'd1;
    localparam logic [7:0] WIRE_SEQ  = 8'd2;
    localparam logic [7:0] WIRE_CSEQ = 8'd3;
    localparam logic [7:0] WIRE_CSET = 8'd4;

    localparam logic [31:0] HASH_SEED = 32'hDEADBEEF;

    // Configuration space
    localparam int          PADDR_W           = 2;
    localparam logic [1:0]  ADDR_ASN_FOUR     = 2'd0;

    // One classified word handed from the front to the back: an optional
    // ASN result followed by an optional closing result.
    typedef struct packed {
        logic        asn_v;
        logic [31:0] asn;
        t_seg_kind   seg_kind;
        logic [7:0]  idx;
        logic        seg_end;
        logic        tail_v;
        t_res_kind   tail_kind;
        logic [15:0] seg_total;
        logic [15:0] first_hash;
        logic [15:0] origin_hash;
        logic        nonempty;
    } t_event;

    function automatic logic [31:0] mix(input logic [31:0] a);
        logic [31:0] a1;
        logic [31:0] a2;
        a1 = a ^ (a >> 4);
        a2 = (a1 ^ HASH_SEED) + (a1 << 5);
        return a2 ^ (a2 >> 11);
    endfunction

endpackage

[design/bgp_as_path_parser.sv]
// Top level of the BGP AS_PATH attribute parser.
//
//   channel  direction  handshake            word
//   input    in         i_valid / o_stall    i_data_byte, i_final_byte
//   output   out        o_valid / i_stall    o_result_kind .. o_last
//   config   in         APB psel/penable     asn_four_bytes at address 0
//
// One byte is taken per cycle while o_stall is low; the front parser updates
// its state for each accepted byte. A byte yields at most two results, which
// the back end delivers one per cycle while i_stall is low, from a QUEUE_DEPTH-
// word queue; each result is held in the output register. Synchronous reset
// clears the parser, queue and output valid. o_stall rises only when the queue
// is full, so the input side stalls only while the output side is held off.
module bgp_as_path_parser
    import bgpap_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_final_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_result_kind,
    output logic [31:0]        o_asn_value,
    output logic [1:0]         o_segment_kind,
    output logic [7:0]         o_member_index,
    output logic               o_segment_end,
    output logic [15:0]        o_segment_total,
    output logic [31:0]        o_route_hash,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

`include "bgp_as_path_parser_assert.svh"

    logic   r_asn_four;
    logic   w_push;
    logic   w_full;
    logic   w_pop;
    logic   w_head_v;
    t_event w_event;
    t_event w_head;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = {31'd0, r_asn_four};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asn_four <= 1'b1;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_ASN_FOUR) begin
            r_asn_four <= pwdata[0];
        end
    end

    bgpap_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .i_asn_four   (r_asn_four),
        .i_q_full     (w_full),
        .o_stall      (o_stall),
        .o_push       (w_push),
        .o_event      (w_event)
    );

    bgpap_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_event    (w_event),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_nonempty (w_head_v),
        .o_head     (w_head)
    );

    bgpap_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_v        (w_head_v),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_result_kind   (o_result_kind),
        .o_asn_value     (o_asn_value),
        .o_segment_kind  (o_segment_kind),
        .o_member_index  (o_member_index),
        .o_segment_end   (o_segment_end),
        .o_segment_total (o_segment_total),
        .o_route_hash    (o_route_hash),
        .o_last          (o_last)
    );

    // Checks
    `BGPAP_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, w_push, !w_full)
    `BGPAP_ASSERT_NOW(a_bad_type_alone, i_clk, i_rst_n,
        w_push && w_event.tail_v && w_event.tail_kind == RES_BAD_TYPE, !w_event.asn_v)
    `BGPAP_ASSERT_NEXT(a_tail_follows, i_clk, i_rst_n, o_valid && !i_stall && !o_last,
        o_valid && o_result_kind != RES_ASN)
    `BGPAP_ASSERT_NOW(a_closing_is_last, i_clk, i_rst_n,
        o_valid && o_result_kind != RES_ASN, o_last)

endmodule

[design/bgpap_front.sv]
// Front end: byte parser that classifies the accepted bytes into result words.
module bgpap_front
    import bgpap_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    input  logic        i_asn_four,
    input  logic        i_q_full,
    output logic        o_stall,
    output logic        o_push,
    output t_event      o_event
);

    t_phase      r_phase, n_phase;
    t_seg_kind   r_type, n_type;
    logic [7:0]  r_rem, n_rem;
    logic [7:0]  r_mem, n_mem;
    logic [1:0]  r_bia, n_bia;
    logic [31:0] r_acc, n_acc;
    logic [15:0] r_first, n_first;
    logic [15:0] r_origin, n_origin;
    logic [15:0] r_count, n_count;
    logic        r_nonempty, n_nonempty;
    logic        r_err, n_err;
    logic        r_fso, n_fso;

    logic        w_accept;
    logic [31:0] w_acc_sh;
    logic        w_asn_done;
    logic        w_end;
    logic        w_bad;
    t_seg_kind   w_kind;
    t_event      w_ev;

    assign o_stall  = i_q_full;
    assign w_accept = i_valid && !i_q_full;
    assign w_acc_sh = {r_acc[23:0], i_data_byte};
    assign w_asn_done = i_asn_four ? (r_bia == 2'd3) : (r_bia != 2'd0);
    assign w_end    = (r_rem <= 8'd1);

    // Decode the segment type byte
    always_comb begin
        w_bad  = 1'b0;
        w_kind = SEG_SEQ;
        unique case (i_data_byte)
            WIRE_SET:  w_kind = SEG_SET;
            WIRE_SEQ:  w_kind = SEG_SEQ;
            WIRE_CSEQ: w_kind = SEG_CSEQ;
            WIRE_CSET: w_kind = SEG_CSET;
            default:   w_bad  = 1'b1;
        endcase
    end

    // Next state and the classified word for an accepted byte
    always_comb begin
        n_phase    = r_phase;
        n_type     = r_type;
        n_rem      = r_rem;
        n_mem      = r_mem;
        n_bia      = r_bia;
        n_acc      = r_acc;
        n_first    = r_first;
        n_origin   = r_origin;
        n_count    = r_count;
        n_nonempty = r_nonempty;
        n_err      = r_err;
        n_fso      = r_fso;
        w_ev       = '0;
        o_push     = 1'b0;

        if (w_accept) begin
            if (r_err) begin
                // drop bytes until the final one
            end else begin
                unique case (r_phase)
                    PH_COUNT: begin
                        n_rem = i_data_byte;
                        n_mem = '0;
                        n_bia = '0;
                        n_acc = '0;
                        if (r_type != SEG_SEQ) begin
                            n_origin = '0;
                            if (!r_nonempty) begin
                                n_nonempty = 1'b1;
                                n_first    = '0;
                                n_fso      = 1'b1;
                            end
                        end
                        if (i_data_byte == 8'd0) begin
                            // empty segment closes at once
                            if (r_type != SEG_SEQ) n_count = r_count + 16'd1;
                            n_fso   = 1'b0;
                            n_phase = PH_TYPE;
                        end else begin
                            n_phase = PH_ASN;
                        end
                    end
                    PH_ASN: begin
                        if (!w_asn_done) begin
                            n_acc = w_acc_sh;
                            n_bia = r_bia + 2'd1;
                        end else begin
                            if (r_type == SEG_SEQ) begin
                                if (!r_nonempty) begin
                                    n_nonempty = 1'b1;
                                    n_first    = w_acc_sh[15:0];
                                end
                                n_origin = w_acc_sh[15:0];
                            end else if (r_mem == 8'd0) begin
                                n_origin = w_acc_sh[15:0];
                                if (r_fso) n_first = w_acc_sh[15:0];
                            end
                            // every sequence hop counts, any other segment counts once on close
                            if (r_type == SEG_SEQ || w_end) n_count = r_count + 16'd1;
                            n_rem = r_rem - 8'd1;
                            n_mem = r_mem + 8'd1;
                            n_bia = '0;
                            n_acc = '0;
                            if (w_end) begin
                                n_fso   = 1'b0;
                                n_phase = PH_TYPE;
                            end
                            w_ev.asn_v    = 1'b1;
                            w_ev.asn      = w_acc_sh;
                            w_ev.seg_kind = r_type;
                            w_ev.idx      = r_mem;
                            w_ev.seg_end  = w_end;
                        end
                    end
                    default: begin
                        if (w_bad) begin
                            w_ev.tail_v    = 1'b1;
                            w_ev.tail_kind = RES_BAD_TYPE;
                            n_err          = 1'b1;
                        end else begin
                            n_type  = w_kind;
                            n_phase = PH_COUNT;
                        end
                    end
                endcase

                // close the path on the final byte
                if (i_final_byte && !w_ev.tail_v) begin
                    w_ev.tail_v      = 1'b1;
                    w_ev.tail_kind   = (n_phase == PH_TYPE) ? RES_DONE : RES_TRUNC;
                    w_ev.first_hash  = n_first;
                    w_ev.origin_hash = n_origin;
                    w_ev.nonempty    = n_nonempty;
                end
                w_ev.seg_total = n_count;
                o_push = w_ev.asn_v || w_ev.tail_v;
            end

            // return path state to reset after the final byte
            if (i_final_byte) begin
                n_phase    = PH_TYPE;
                n_type     = SEG_SEQ;
                n_rem      = '0;
                n_mem      = '0;
                n_bia      = '0;
                n_acc      = '0;
                n_first    = '0;
                n_origin   = '0;
                n_count    = '0;
                n_nonempty = 1'b0;
                n_err      = 1'b0;
                n_fso      = 1'b0;
            end
        end
    end

    assign o_event = w_ev;

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TYPE;
            r_type     <= SEG_SEQ;
            r_rem      <= '0;
            r_mem      <= '0;
            r_bia      <= '0;
            r_acc      <= '0;
            r_first    <= '0;
            r_origin   <= '0;
            r_count    <= '0;
            r_nonempty <= 1'b0;
            r_err      <= 1'b0;
            r_fso      <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_type     <= n_type;
            r_rem      <= n_rem;
            r_mem      <= n_mem;
            r_bia      <= n_bia;
            r_acc      <= n_acc;
            r_first    <= n_first;
            r_origin   <= n_origin;
            r_count    <= n_count;
            r_nonempty <= n_nonempty;
            r_err      <= n_err;
            r_fso      <= n_fso;
        end
    end

endmodule

[design/bgpap_queue.sv]
// Short queue of classified words between the front and the back.
module bgpap_queue
    import bgpap_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_event,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_nonempty,
    output t_event o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_event             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    assign o_full     = (r_cnt == CNT_W'(DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_head     = r_mem[r_rd];

    // Advance pointers and occupancy
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        if (i_pop)  n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        if (i_push && !i_pop) n_cnt = r_cnt + 1'b1;
        else if (!i_push && i_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store words
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_event;
    end

endmodule

[design/bgpap_back.sv]
// Back end: expands queued words into results and holds the output register.
module bgpap_back
    import bgpap_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_head_v,
    input  t_event      i_head,
    output logic        o_pop,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [1:0]  o_result_kind,
    output logic [31:0] o_asn_value,
    output logic [1:0]  o_segment_kind,
    output logic [7:0]  o_member_index,
    output logic        o_segment_end,
    output logic [15:0] o_segment_total,
    output logic [31:0] o_route_hash,
    output logic        o_last
);

    logic        r_valid, n_valid;
    logic        r_sent, n_sent;
    t_res_kind   r_kind, n_kind;
    logic [31:0] r_asn, n_asn;
    t_seg_kind   r_seg, n_seg;
    logic [7:0]  r_idx, n_idx;
    logic        r_end, n_end;
    logic [15:0] r_total, n_total;
    logic [31:0] r_hash, n_hash;
    logic        r_last, n_last;

    logic        w_free;
    logic        w_take;
    logic [31:0] w_hash_in;

    assign w_free    = !r_valid || !i_stall;
    assign w_take    = w_free && i_head_v;
    assign w_hash_in = {8'd0, i_head.first_hash, 8'd0} | {16'd0, i_head.origin_hash};

    // Select the next result from the head word
    always_comb begin
        n_valid = r_valid;
        n_sent  = r_sent;
        n_kind  = r_kind;
        n_asn   = r_asn;
        n_seg   = r_seg;
        n_idx   = r_idx;
        n_end   = r_end;
        n_total = r_total;
        n_hash  = r_hash;
        n_last  = r_last;
        o_pop   = 1'b0;

        if (w_take) begin
            n_valid = 1'b1;
            n_total = i_head.seg_total;
            if (i_head.asn_v && !r_sent) begin
                n_kind = RES_ASN;
                n_asn  = i_head.asn;
                n_seg  = i_head.seg_kind;
                n_idx  = i_head.idx;
                n_end  = i_head.seg_end;
                n_hash = '0;
                n_last = !i_head.tail_v;
                n_sent = i_head.tail_v;
                o_pop  = !i_head.tail_v;
            end else begin
                n_kind = i_head.tail_kind;
                n_asn  = '0;
                n_seg  = SEG_SEQ;
                n_idx  = '0;
                n_end  = 1'b0;
                n_hash = (i_head.tail_kind == RES_DONE && i_head.nonempty) ?
                         mix(w_hash_in) : '0;
                n_last = 1'b1;
                n_sent = 1'b0;
                o_pop  = 1'b1;
            end
        end else if (w_free) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sent  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sent  <= n_sent;
        end
    end

    // Hold the result payload
    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_asn   <= n_asn;
        r_seg   <= n_seg;
        r_idx   <= n_idx;
        r_end   <= n_end;
        r_total <= n_total;
        r_hash  <= n_hash;
        r_last  <= n_last;
    end

    assign o_valid         = r_valid;
    assign o_result_kind   = r_kind;
    assign o_asn_value     = r_asn;
    assign o_segment_kind  = r_seg;
    assign o_member_index  = r_idx;
    assign o_segment_end   = r_end;
    assign o_segment_total = r_total;
    assign o_route_hash    = r_hash;
    assign o_last          = r_last;

endmodule
